@@ rtl/core/marching_cubes_cell_mesher_core_assert.svh @@
// Assertion macros of the mesher RTL.
`ifndef MARCHING_CUBES_CELL_MESHER_CORE_ASSERT_SVH
`define MARCHING_CUBES_CELL_MESHER_CORE_ASSERT_SVH

// Checked at every rising clock edge while the block is out of reset.
`define MCCM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every rising clock edge, reset included.
`define MCCM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/core/mccm_pkg.sv @@
// Types, constants and lookup tables of the marching cubes cell mesher.
`default_nettype none
package mccm_pkg;

    localparam int REGION_SIDE_DEFAULT = 16;
    localparam int COORD_W = 4;
    localparam int VOXEL_W = 8;
    localparam int POS_W = 6;
    localparam int INDEX_W = 14;
    localparam int DIM_W = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int CALC_W = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_DIM_X = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DIM_Y = 1'd1;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_TRI = 1'b1;

    localparam logic [3:0] ROW_END = 4'hf;

    typedef struct packed {
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_z;
        logic [VOXEL_W-1:0] corner_000;
        logic [VOXEL_W-1:0] corner_100;
        logic [VOXEL_W-1:0] corner_010;
        logic [VOXEL_W-1:0] corner_110;
        logic [VOXEL_W-1:0] corner_001;
        logic [VOXEL_W-1:0] corner_101;
        logic [VOXEL_W-1:0] corner_011;
        logic [VOXEL_W-1:0] corner_111;
    } cell_req_t;

    typedef struct packed {
        logic               item_kind;
        logic [POS_W-1:0]   pos_x_half;
        logic [POS_W-1:0]   pos_y_half;
        logic [POS_W-1:0]   pos_z_half;
        logic [1:0]         normal_axis;
        logic               normal_negative;
        logic [VOXEL_W-1:0] material;
        logic [INDEX_W-1:0] index_a;
        logic [INDEX_W-1:0] index_b;
        logic [INDEX_W-1:0] index_c;
        logic               last;
    } mesh_item_t;

    typedef struct packed {
        logic [1:0] ox;
        logic [1:0] oy;
        logic [1:0] oz;
        logic [1:0] axis;
        logic [2:0] ca;
        logic [2:0] cb;
    } edge_t;

    typedef logic [15:0][3:0] tri_row_t;

    // Each row holds the edge digits of the case, first digit highest, under an end marker.
    localparam logic [63:0] TRI_ROM [256] = '{
        64'hf, 64'hf083, 64'hf019, 64'hf183981,
        64'hf12a, 64'hf08312a, 64'hf92a029, 64'hf2832a8a98,
        64'hf3b2, 64'hf0b28b0, 64'hf19023b, 64'hf1b219b98b,
        64'hf3a1ba3, 64'hf0a108a8ba, 64'hf3903b9ba9, 64'hf98aa8b,
        64'hf478, 64'hf430734, 64'hf019847, 64'hf419471731,
        64'hf12a847, 64'hf34730412a, 64'hf92a902847, 64'hf2a9297273794,
        64'hf8473b2, 64'hfb47b24204, 64'hf90184723b, 64'hf47b94b9b2921,
        64'hf3a13ba784, 64'hf1ba14b1047b4, 64'hf47890b9bab03, 64'hf47b4b99ba,
        64'hf954, 64'hf954083, 64'hf054150, 64'hf854835315,
        64'hf12a954, 64'hf30812a495, 64'hf52a542402, 64'hf2a5325354348,
        64'hf95423b, 64'hf0b208b495, 64'hf05401523b, 64'hf21525828b485,
        64'hfa3ba13954, 64'hf4950818a18ba, 64'hf54050b5bab03, 64'hf54858aa8b,
        64'hf978579, 64'hf930953573, 64'hf078017157, 64'hf153357,
        64'hf978957a12, 64'hfa12950530573, 64'hf802825857a52, 64'hf2a5253357,
        64'hf7957893b2, 64'hf95797292027b, 64'hf23b018178157, 64'hfb21b17715,
        64'hf958857a13a3b, 64'hf5705097b010aba0, 64'hfba0b03a50807570, 64'hfba57b5,
        64'hfa65, 64'hf0835a6, 64'hf9015a6, 64'hf1831985a6,
        64'hf165261, 64'hf165126308, 64'hf965906026, 64'hf598582526328,
        64'hf23ba65, 64'hfb08b20a65, 64'hf01923b5a6, 64'hf5a61929b298b,
        64'hf63b653513, 64'hf08b0b50515b6, 64'hf3b6036065059, 64'hf65969bb98,
        64'hf5a6478, 64'hf43047365a, 64'hf1905a6847, 64'hfa65197173794,
        64'hf612651478, 64'hf125526304347, 64'hf847905065026, 64'hf739794329596269,
        64'hf3b2784a65, 64'hf5a647242027b, 64'hf01947823b5a6, 64'hf9219b294b7b45a6,
        64'hf8473b53515b6, 64'hf51b5b610b7b404b, 64'hf059065036b63847, 64'hf65969b4797b9,
        64'hfa4964a, 64'hf4a649a083, 64'hfa01a60640, 64'hf83181686461a,
        64'hf149124264, 64'hf308129249264, 64'hf024426, 64'hf832824426,
        64'hfa49a64b23, 64'hf08228b49a4a6, 64'hf3b201606461a, 64'hf64161a48121b8b1,
        64'hf964936913b63, 64'hf8b1810b61914641, 64'hf3b6360064, 64'hf648b68,
        64'hf7a678a89a, 64'hf0730a709a67a, 64'hfa671a7178180, 64'hfa67a71173,
        64'hf126168189867, 64'hf269291679093739, 64'hf780706602, 64'hf732672,
        64'hf23ba68a89867, 64'hf20727b09767a9a7, 64'hf1801781a767a23b, 64'hfb21b17a61671,
        64'hf896867916b63136, 64'hf091b67, 64'hf7807063b0b60, 64'hf7b6,
        64'hf76b, 64'hf308b76, 64'hf019b76, 64'hf819831b76,
        64'hfa126b7, 64'hf12a3086b7, 64'hf2902a96b7, 64'hf6b72a3a83a98,
        64'hf723627, 64'hf708760620, 64'hf276237019, 64'hf162186198876,
        64'hfa76a17137, 64'hfa7617a187108, 64'hf03707a0a96a7, 64'hf76a7a88a9,
        64'hf684b86, 64'hf36b306046, 64'hf86b846901, 64'hf946963931b36,
        64'hf6846b82a1, 64'hf12a30b06b046, 64'hf4b846b0292a9, 64'hfa93a32943b36463,
        64'hf823842462, 64'hf042462, 64'hf190234246438, 64'hf194142246,
        64'hf8138618466a1, 64'hfa10a06604, 64'hf4634386a3039a93, 64'hfa946a4,
        64'hf49576b, 64'hf083495b76, 64'hf50154076b, 64'hfb76834354315,
        64'hf954a1276b, 64'hf6b712a083495, 64'hf76b54a42a402, 64'hf348354325a52b76,
        64'hf723762549, 64'hf954086062687, 64'hf362376150540, 64'hf628687218485158,
        64'hf954a16176137, 64'hf16a176107870954, 64'hf40a4a503a6a737a, 64'hf76a7a854a48a,
        64'hf6956b9b89, 64'hf36b063056095, 64'hf0b805b01556b, 64'hf6b3635531,
        64'hf12a95b9b8b56, 64'hf0b306b09656912a, 64'hfb85b56805a52025, 64'hf6b36352a3a53,
        64'hf589528562382, 64'hf956960062, 64'hf158180568382628, 64'hf156216,
        64'hf13616a386569896, 64'hfa10a06950560, 64'hf03856a, 64'hfa56,
        64'hfb5a75b, 64'hfb5ab75830, 64'hf5b75ab190, 64'hfa75ab7981831,
        64'hfb12b71751, 64'hf08312717572b, 64'hf9759279022b7, 64'hf75272b592328982,
        64'hf25a235375, 64'hf820852875a25, 64'hf9015a35373a2, 64'hf982921872a25752,
        64'hf135375, 64'hf087071175, 64'hf903935537, 64'hf987597,
        64'hf5845a8ab8, 64'hf5045b05abb30, 64'hf01984a8aba45, 64'hfab4a45b34941314,
        64'hf2512852b8458, 64'hf04b0b345b2b151b, 64'hf0250592b5458b85, 64'hf9452b3,
        64'hf25a352345384, 64'hf5a2524420, 64'hf3a235a385458019, 64'hf5a2524192942,
        64'hf845853351, 64'hf045105, 64'hf845853905035, 64'hf945,
        64'hf4b749b9ab, 64'hf0834979b79ab, 64'hf1ab1b414074b, 64'hf3143481a474bab4,
        64'hf4b79b492b912, 64'hf9749b791b2b1083, 64'hfb74b42240, 64'hfb74b42834324,
        64'hf29a279237749, 64'hf9a7974a27870207, 64'hf37a3a274a1a040a, 64'hf1a2874,
        64'hf491417713, 64'hf491417081871, 64'hf403743, 64'hf487,
        64'hf9a8ab8, 64'hf30939bb9a, 64'hf01a0a88ab, 64'hf31ab3a,
        64'hf12b1b99b8, 64'hf30939b1292b9, 64'hf02b80b, 64'hf32b,
        64'hf23828aa89, 64'hf9a2092, 64'hf23828a0181a8, 64'hf1a2,
        64'hf138918, 64'hf091, 64'hf038, 64'hf
    };

    function automatic edge_t edge_info(input logic [3:0] digit);
        edge_t e;
        case (digit)
            4'd1:    e = '{2'd2, 2'd1, 2'd0, AXIS_Y, 3'd1, 3'd2};
            4'd2:    e = '{2'd1, 2'd2, 2'd0, AXIS_X, 3'd3, 3'd2};
            4'd3:    e = '{2'd0, 2'd1, 2'd0, AXIS_Y, 3'd0, 3'd3};
            4'd4:    e = '{2'd1, 2'd0, 2'd2, AXIS_X, 3'd4, 3'd5};
            4'd5:    e = '{2'd2, 2'd1, 2'd2, AXIS_Y, 3'd5, 3'd6};
            4'd6:    e = '{2'd1, 2'd2, 2'd2, AXIS_X, 3'd7, 3'd6};
            4'd7:    e = '{2'd0, 2'd1, 2'd2, AXIS_Y, 3'd4, 3'd7};
            4'd8:    e = '{2'd0, 2'd0, 2'd1, AXIS_Z, 3'd0, 3'd4};
            4'd9:    e = '{2'd2, 2'd0, 2'd1, AXIS_Z, 3'd1, 3'd5};
            4'd10:   e = '{2'd2, 2'd2, 2'd1, AXIS_Z, 3'd2, 3'd6};
            4'd11:   e = '{2'd0, 2'd2, 2'd1, AXIS_Z, 3'd3, 3'd7};
            default: e = '{2'd1, 2'd0, 2'd0, AXIS_X, 3'd0, 3'd1};
        endcase
        return e;
    endfunction

    function automatic logic [3:0] row_digits(input tri_row_t row);
        logic [3:0] n;
        n = '0;
        for (int i = 1; i < 16; i++)
        begin
            if (row[i] == ROW_END)
            begin
                n = 4'(i);
            end
        end
        return n;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/mccm_if.sv @@
// Valid/ready channel interfaces for cell requests and mesh items.
`default_nettype none
interface mccm_cell_if;
    import mccm_pkg::*;
    logic      valid;
    logic      ready;
    cell_req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mccm_item_if;
    import mccm_pkg::*;
    logic       valid;
    logic       ready;
    mesh_item_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ rtl/core/marching_cubes_cell_mesher_core.sv @@
// Marching cubes cell mesher: turns cube cells into shared vertices and triangles.
// The cell channel takes one request per cube cell: its lower corner and eight voxels.
// The mesh channel returns, for each triangle of the cell, a vertex item for each
// corner edge that has no vertex yet, then the triangle item; the final item of a
// cell carries last. A cell with no crossing returns nothing.
// A request is taken only while the block is idle. Each triangle corner takes a
// read of its per-axis edge store followed by the check and write-back, and each
// triangle one more step to load its triangle item into the output register.
// The edge stores are single-port memories with a registered read.
// A finished item waits in the output register; a stalled receiver holds the
// sequencer at its next item and nothing is lost.
// After reset the block sweeps the edge stores to empty, one entry a cycle over all
// (REGION_SIDE + 1) cubed entries, 4913 by default, and takes no request meanwhile.
// Configuration writes of dim_x and dim_y are taken at any time, and belong in
// idle periods. The vertex counter restarts at zero at reset.
`default_nettype none
`include "marching_cubes_cell_mesher_core_assert.svh"
module marching_cubes_cell_mesher_core #(
    parameter int REGION_SIDE = mccm_pkg::REGION_SIDE_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    mccm_cell_if.sink                           cells,
    mccm_item_if.source                         mesh,
    input  logic                                cfg_we,
    input  logic [mccm_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [mccm_pkg::DIM_W-1:0]          cfg_data
);
    import mccm_pkg::*;

    localparam int STORE_DEPTH = (REGION_SIDE + 1) * (REGION_SIDE + 1) * (REGION_SIDE + 1);
    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int ENTRY_W = INDEX_W + 1;
    localparam int CMP_W = (ADDR_W + 1 > CALC_W) ? ADDR_W + 1 : CALC_W;
    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(REGION_SIDE + 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_READ  = 5'b00100,
        S_LOOK  = 5'b01000,
        S_TRI   = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [ADDR_W-1:0]       clr_reg;
    logic [DIM_W-1:0]        dim_x_reg, dim_y_reg;
    logic [2*DIM_W-1:0]      dxy_reg;
    logic [COORD_W-1:0]      cx_reg, cy_reg, cz_reg;
    logic [VOXEL_W-1:0]      corner_reg [8];
    tri_row_t                row_reg;
    logic [3:0]              rem_reg;
    logic [1:0]              slot_reg;
    logic [INDEX_W-1:0]      idx_reg [3];
    logic [INDEX_W-1:0]      counter_reg;
    logic [ADDR_W-1:0]       addr_reg;
    logic                    inside_reg;
    edge_t                   edge_reg;
    logic [POS_W-1:0]        px_reg, py_reg, pz_reg;
    logic                    neg_reg;
    logic [VOXEL_W-1:0]      mat_reg;
    mesh_item_t              out_reg;
    logic                    out_valid_reg;

    logic [ENTRY_W-1:0]      x_mem [STORE_DEPTH];
    logic [ENTRY_W-1:0]      y_mem [STORE_DEPTH];
    logic [ENTRY_W-1:0]      z_mem [STORE_DEPTH];
    logic [ENTRY_W-1:0]      rd_x_reg, rd_y_reg, rd_z_reg;

    logic                    accept;
    logic [7:0]              cube;
    tri_row_t                row_in;
    logic [3:0]              digits_in;
    logic [3:0]              digit;
    edge_t                   edge_cur;
    logic [DIM_W-1:0]        xi, yi, zi;
    logic [2*DIM_W-1:0]      prod_y;
    logic [3*DIM_W-1:0]      prod_z;
    logic [CMP_W-1:0]        addr_full;
    logic                    in_range;
    logic [VOXEL_W-1:0]      va, vb;
    logic [ENTRY_W-1:0]      rd_sel;
    logic                    hit;
    logic                    out_free;
    logic                    emit_vertex;
    logic                    advance;
    logic                    tri_load;
    logic [INDEX_W-1:0]      idx_new;
    logic                    clearing;
    logic                    mem_re;
    logic [ADDR_W-1:0]       mem_waddr;
    logic [ENTRY_W-1:0]      mem_wdata;
    logic                    we_x, we_y, we_z;
    mesh_item_t              item_next;

    assign clearing = (state_reg == S_CLEAR);
    assign cells.ready = (state_reg == S_IDLE);
    assign accept = cells.valid && cells.ready;
    assign mesh.valid = out_valid_reg;
    assign mesh.payload = out_reg;

    assign cube = {cells.payload.corner_011 == '0, cells.payload.corner_111 == '0,
                   cells.payload.corner_101 == '0, cells.payload.corner_001 == '0,
                   cells.payload.corner_010 == '0, cells.payload.corner_110 == '0,
                   cells.payload.corner_100 == '0, cells.payload.corner_000 == '0};
    assign row_in = TRI_ROM[cube];
    assign digits_in = row_digits(row_in);

    assign digit = row_reg[rem_reg - 4'd1];
    assign edge_cur = edge_info(digit);
    assign xi = DIM_W'(cx_reg) + DIM_W'(edge_cur.ox[1]);
    assign yi = DIM_W'(cy_reg) + DIM_W'(edge_cur.oy[1]);
    assign zi = DIM_W'(cz_reg) + DIM_W'(edge_cur.oz[1]);
    assign prod_y = (2*DIM_W)'(yi) * (2*DIM_W)'(dim_x_reg);
    assign prod_z = (3*DIM_W)'(zi) * (3*DIM_W)'(dxy_reg);
    assign addr_full = CMP_W'(xi) + CMP_W'(prod_y) + CMP_W'(prod_z);
    assign in_range = addr_full < CMP_W'(STORE_DEPTH);
    assign va = corner_reg[edge_cur.ca];
    assign vb = corner_reg[edge_cur.cb];

    always_comb
    begin
        case (edge_reg.axis)
            AXIS_X:  rd_sel = rd_x_reg;
            AXIS_Y:  rd_sel = rd_y_reg;
            default: rd_sel = rd_z_reg;
        endcase
    end

    assign hit = inside_reg && rd_sel[ENTRY_W-1];
    assign out_free = !out_valid_reg || mesh.ready;
    assign emit_vertex = (state_reg == S_LOOK) && !hit && out_free;
    assign advance = (state_reg == S_LOOK) && (hit || out_free);
    assign tri_load = (state_reg == S_TRI) && out_free;
    assign idx_new = hit ? rd_sel[INDEX_W-1:0] : counter_reg;

    assign mem_re = (state_reg == S_READ) && in_range;
    assign mem_waddr = clearing ? clr_reg : addr_reg;
    assign mem_wdata = clearing ? '0 : {1'b1, counter_reg};
    assign we_x = clearing || (emit_vertex && inside_reg && edge_reg.axis == AXIS_X);
    assign we_y = clearing || (emit_vertex && inside_reg && edge_reg.axis == AXIS_Y);
    assign we_z = clearing || (emit_vertex && inside_reg && edge_reg.axis == AXIS_Z);

    always_ff @(posedge clk)
    begin
        if (we_x)
        begin
            x_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_x_reg <= x_mem[addr_full[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_y)
        begin
            y_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_y_reg <= y_mem[addr_full[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_z)
        begin
            z_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_z_reg <= z_mem[addr_full[ADDR_W-1:0]];
        end
    end

    always_comb
    begin
        item_next = '0;
        if (emit_vertex)
        begin
            item_next.item_kind = KIND_VERTEX;
            item_next.pos_x_half = px_reg;
            item_next.pos_y_half = py_reg;
            item_next.pos_z_half = pz_reg;
            item_next.normal_axis = edge_reg.axis;
            item_next.normal_negative = neg_reg;
            item_next.material = mat_reg;
            item_next.index_a = counter_reg;
        end
        else
        begin
            item_next.item_kind = KIND_TRI;
            item_next.index_a = idx_reg[0];
            item_next.index_b = idx_reg[1];
            item_next.index_c = idx_reg[2];
            item_next.last = (rem_reg == '0);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (clr_reg == ADDR_W'(STORE_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept && digits_in != '0)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                if (advance)
                begin
                    state_next = (slot_reg == 2'd2) ? S_TRI : S_READ;
                end
            end
            S_TRI:
            begin
                if (out_free)
                begin
                    state_next = (rem_reg == '0) ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            dim_x_reg <= DIM_RESET;
            dim_y_reg <= DIM_RESET;
            rem_reg <= '0;
            slot_reg <= '0;
            counter_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DIM_X: dim_x_reg <= cfg_data;
                    REG_DIM_Y: dim_y_reg <= cfg_data;
                    default:   dim_x_reg <= dim_x_reg;
                endcase
            end
            if (accept)
            begin
                rem_reg <= digits_in;
                slot_reg <= '0;
            end
            if (advance)
            begin
                rem_reg <= rem_reg - 4'd1;
                slot_reg <= (slot_reg == 2'd2) ? 2'd0 : slot_reg + 2'd1;
            end
            if (emit_vertex)
            begin
                counter_reg <= counter_reg + 1'b1;
            end
            if (emit_vertex || tri_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (mesh.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cx_reg <= cells.payload.cell_x;
            cy_reg <= cells.payload.cell_y;
            cz_reg <= cells.payload.cell_z;
            corner_reg[0] <= cells.payload.corner_000;
            corner_reg[1] <= cells.payload.corner_100;
            corner_reg[2] <= cells.payload.corner_110;
            corner_reg[3] <= cells.payload.corner_010;
            corner_reg[4] <= cells.payload.corner_001;
            corner_reg[5] <= cells.payload.corner_101;
            corner_reg[6] <= cells.payload.corner_111;
            corner_reg[7] <= cells.payload.corner_011;
            row_reg <= row_in;
            dxy_reg <= (2*DIM_W)'(dim_x_reg) * (2*DIM_W)'(dim_y_reg);
        end
        if (state_reg == S_READ)
        begin
            addr_reg <= addr_full[ADDR_W-1:0];
            inside_reg <= in_range;
            edge_reg <= edge_cur;
            px_reg <= {1'b0, cx_reg, 1'b0} + POS_W'(edge_cur.ox);
            py_reg <= {1'b0, cy_reg, 1'b0} + POS_W'(edge_cur.oy);
            pz_reg <= {1'b0, cz_reg, 1'b0} + POS_W'(edge_cur.oz);
            neg_reg <= !(va > vb);
            mat_reg <= va | vb;
        end
        if (advance)
        begin
            idx_reg[slot_reg] <= idx_new;
        end
        if (emit_vertex || tri_load)
        begin
            out_reg <= item_next;
        end
    end

    `MCCM_ASSERT(a_no_request_while_clearing, clearing |-> !cells.ready,
                 "request accepted during the edge store sweep")
    `MCCM_ASSERT(a_counter_steps, emit_vertex |=> counter_reg == $past(counter_reg) + 1'b1,
                 "vertex counter did not step with a new vertex")
    `MCCM_ASSERT(a_last_is_triangle,
                 (mesh.valid && mesh.payload.last) |-> mesh.payload.item_kind == KIND_TRI,
                 "last flag on a vertex item")
    `MCCM_ASSERT_ALWAYS(a_store_port_exclusive, !(mem_re && (we_x || we_y || we_z)),
                        "edge store read and written in the same cycle")

endmodule
`default_nettype wire

@@ tb/marching_cubes_cell_mesher_core_test.sv @@
// Self-checking testbench of the marching cubes cell mesher with its own mesh predictor.
`timescale 1ns / 1ps
module marching_cubes_cell_mesher_core_test;
    import mccm_pkg::*;

    localparam int STORE_DEPTH = 4913;
    localparam int SETTLE_CYCLES = 60;
    localparam int IDLE_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_DIM_X;
    logic [DIM_W-1:0] cfg_data = '0;

    mccm_cell_if cells ();
    mccm_item_if mesh ();

    marching_cubes_cell_mesher_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .cells(cells.sink),
        .mesh(mesh.source),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Per edge: half-unit offsets x, y, z, axis, first and second end corner.
    int edge_tab [12][6] = '{
        '{1, 0, 0, 0, 0, 1}, '{2, 1, 0, 1, 1, 2}, '{1, 2, 0, 0, 3, 2}, '{0, 1, 0, 1, 0, 3},
        '{1, 0, 2, 0, 4, 5}, '{2, 1, 2, 1, 5, 6}, '{1, 2, 2, 0, 7, 6}, '{0, 1, 2, 1, 4, 7},
        '{0, 0, 1, 2, 0, 4}, '{2, 0, 1, 2, 1, 5}, '{2, 2, 1, 2, 2, 6}, '{0, 2, 1, 2, 3, 7}
    };

    logic [14:0] edge_store [3][STORE_DEPTH];
    logic [INDEX_W-1:0] next_vertex = '0;
    int dim_x_now = 17;
    int dim_y_now = 17;

    cell_req_t pending_cells [$];
    mesh_item_t mesh_expect [$];
    int errors = 0;
    int idle_cycles = 0;
    int cell_gap = 0;
    int mesh_stall = 0;
    bit no_idle = 1'b0;

    initial
    begin
        for (int a = 0; a < 3; a++)
        begin
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                edge_store[a][i] = '0;
            end
        end
        cells.valid = 1'b0;
        cells.payload = '0;
        mesh.ready = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic predict_mesh(input cell_req_t req);
        logic [7:0] c [8];
        logic [7:0] cube;
        logic [63:0] row;
        int n;
        int count;
        int d;
        int hx;
        int hy;
        int hz;
        int ax;
        int addr;
        logic [14:0] entry;
        logic [INDEX_W-1:0] idx [3];
        mesh_item_t it;
        c[0] = req.corner_000;
        c[1] = req.corner_100;
        c[2] = req.corner_110;
        c[3] = req.corner_010;
        c[4] = req.corner_001;
        c[5] = req.corner_101;
        c[6] = req.corner_111;
        c[7] = req.corner_011;
        cube = '0;
        for (int j = 0; j < 8; j++)
        begin
            cube[j] = (c[j] == 8'd0);
        end
        row = TRI_ROM[cube];
        n = 0;
        for (int i = 1; i < 16; i++)
        begin
            if (row[i*4 +: 4] == 4'hf)
            begin
                n = i;
            end
        end
        count = 0;
        for (int t = 0; t + 3 <= n; t += 3)
        begin
            for (int j = 0; j < 3; j++)
            begin
                d = row[(n - 1 - t - j)*4 +: 4];
                if (d > 11)
                begin
                    d = 0;
                end
                hx = 2 * req.cell_x + edge_tab[d][0];
                hy = 2 * req.cell_y + edge_tab[d][1];
                hz = 2 * req.cell_z + edge_tab[d][2];
                ax = edge_tab[d][3];
                addr = (hx >> 1) + (hy >> 1) * dim_x_now + (hz >> 1) * dim_x_now * dim_y_now;
                entry = (addr < STORE_DEPTH) ? edge_store[ax][addr] : 15'd0;
                if (entry[14])
                begin
                    idx[j] = entry[13:0];
                end
                else
                begin
                    idx[j] = next_vertex;
                    it = '0;
                    it.item_kind = KIND_VERTEX;
                    it.pos_x_half = POS_W'(hx);
                    it.pos_y_half = POS_W'(hy);
                    it.pos_z_half = POS_W'(hz);
                    it.normal_axis = 2'(ax);
                    it.normal_negative = !(c[edge_tab[d][4]] > c[edge_tab[d][5]]);
                    it.material = c[edge_tab[d][4]] | c[edge_tab[d][5]];
                    it.index_a = next_vertex;
                    mesh_expect.push_back(it);
                    count++;
                    if (addr < STORE_DEPTH)
                    begin
                        edge_store[ax][addr] = {1'b1, next_vertex};
                    end
                    next_vertex = next_vertex + 1'b1;
                end
            end
            it = '0;
            it.item_kind = KIND_TRI;
            it.index_a = idx[0];
            it.index_b = idx[1];
            it.index_c = idx[2];
            mesh_expect.push_back(it);
            count++;
        end
        if (count > 0)
        begin
            mesh_expect[mesh_expect.size() - 1].last = 1'b1;
        end
    endtask

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cells.valid <= 1'b0;
            cell_gap <= 0;
        end
        else
        begin
            if (cells.valid && cells.ready)
            begin
                predict_mesh(cells.payload);
            end
            if (!cells.valid || cells.ready)
            begin
                if (cell_gap > 0)
                begin
                    cell_gap <= cell_gap - 1;
                    cells.valid <= 1'b0;
                end
                else if (pending_cells.size() > 0)
                begin
                    cells.valid <= 1'b1;
                    cells.payload <= pending_cells.pop_front();
                    cell_gap <= pick_gap();
                end
                else
                begin
                    cells.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        mesh_item_t want;
        if (!rst_n)
        begin
            mesh.ready <= 1'b0;
            mesh_stall <= 0;
        end
        else
        begin
            if (mesh.valid && mesh.ready)
            begin
                if (mesh_expect.size() == 0)
                begin
                    $error("mesh item with nothing expected");
                    errors++;
                end
                else
                begin
                    want = mesh_expect.pop_front();
                    check_field("item_kind", want.item_kind, mesh.payload.item_kind);
                    check_field("pos_x_half", want.pos_x_half, mesh.payload.pos_x_half);
                    check_field("pos_y_half", want.pos_y_half, mesh.payload.pos_y_half);
                    check_field("pos_z_half", want.pos_z_half, mesh.payload.pos_z_half);
                    check_field("normal_axis", want.normal_axis, mesh.payload.normal_axis);
                    check_field("normal_negative", want.normal_negative,
                                mesh.payload.normal_negative);
                    check_field("material", want.material, mesh.payload.material);
                    check_field("index_a", want.index_a, mesh.payload.index_a);
                    check_field("index_b", want.index_b, mesh.payload.index_b);
                    check_field("index_c", want.index_c, mesh.payload.index_c);
                    check_field("last", want.last, mesh.payload.last);
                end
            end
            if (mesh_stall > 0)
            begin
                mesh_stall <= mesh_stall - 1;
                mesh.ready <= 1'b0;
            end
            else
            begin
                mesh.ready <= 1'b1;
                if ($urandom_range(0, 4) == 0)
                begin
                    mesh_stall <= pick_gap();
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cells.valid && cells.ready) || (mesh.valid && mesh.ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("marching_cubes_cell_mesher_core regression: fail");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [7:0] rand_voxel();
        if ($urandom_range(0, 1) == 0)
        begin
            return 8'd0;
        end
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic cell_req_t make_cell(input int x, input int y, input int z,
                                            input logic [63:0] corners);
        cell_req_t r;
        r.cell_x = COORD_W'(x);
        r.cell_y = COORD_W'(y);
        r.cell_z = COORD_W'(z);
        {r.corner_000, r.corner_100, r.corner_010, r.corner_110,
         r.corner_001, r.corner_101, r.corner_011, r.corner_111} = corners;
        return r;
    endfunction

    function automatic logic [63:0] rand_corners();
        logic [63:0] v;
        for (int i = 0; i < 8; i++)
        begin
            v[i*8 +: 8] = rand_voxel();
        end
        return v;
    endfunction

    task automatic write_dims(input int dx, input int dy);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= REG_DIM_X;
        cfg_data <= DIM_W'(dx);
        @(posedge clk);
        cfg_index <= REG_DIM_Y;
        cfg_data <= DIM_W'(dy);
        @(posedge clk);
        cfg_we <= 1'b0;
        dim_x_now = dx;
        dim_y_now = dy;
    endtask

    task automatic queue_random_cells(input int count, input int box);
        int x;
        int y;
        int z;
        x = 0;
        y = 0;
        z = 0;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                // Neighboring cells of a small box share edges with each other.
                pending_cells.push_back(make_cell(x, y, z, rand_corners()));
                x++;
                if (x == box)
                begin
                    x = 0;
                    y++;
                    if (y == box)
                    begin
                        y = 0;
                        z = (z + 1) % 16;
                    end
                end
            end
            else
            begin
                pending_cells.push_back(make_cell($urandom_range(0, 15), $urandom_range(0, 15),
                                                  $urandom_range(0, 15), rand_corners()));
            end
        end
    endtask

    task automatic drain();
        wait (pending_cells.size() == 0 && !cells.valid);
        wait (mesh_expect.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        write_dims(17, 17);

        pending_cells.push_back(make_cell(0, 0, 0, 64'h0));
        pending_cells.push_back(make_cell(15, 15, 15, {8{8'hff}}));
        for (int i = 0; i < 8; i++)
        begin
            pending_cells.push_back(make_cell(i, 0, 15 - i, 64'hff << (i * 8)));
            pending_cells.push_back(make_cell(15, i, i, ~(64'hff << (i * 8)) & {8{8'h80}}
                                              | (64'h01 << (i * 8))));
        end
        pending_cells.push_back(make_cell(15, 15, 15, 64'h00ff_00ff_ff00_ff00));
        pending_cells.push_back(make_cell(0, 15, 0, 64'h0180_4020_1008_0402));
        pending_cells.push_back(make_cell(15, 0, 15, 64'h00ff_0000_00ff_0000));
        pending_cells.push_back(make_cell(14, 15, 15, 64'h00ff_00ff_ff00_ff00));
        drain();

        no_idle = 1'b1;
        queue_random_cells(25, 3);
        drain();
        no_idle = 1'b0;
        queue_random_cells(25, 4);
        drain();

        write_dims(2, 2);
        queue_random_cells(20, 2);
        drain();

        write_dims(31, 0);
        queue_random_cells(15, 3);
        drain();

        write_dims(9, 13);
        queue_random_cells(20, 5);
        drain();

        write_dims(17, 17);
        queue_random_cells(30, 16);
        drain();

        if (errors == 0 && mesh_expect.size() == 0)
        begin
            $display("marching_cubes_cell_mesher_core regression: pass");
        end
        else
        begin
            $display("marching_cubes_cell_mesher_core regression: fail");
        end
        $finish;
    end
endmodule
